FILE: rtl/cci_pkg.sv
// Shared types, widths and arithmetic step functions for the circle intersection block.
// Has no dependencies; the top level and its checker import it.
package cci_pkg;

    localparam int CW = 32;
    localparam int DW = CW + 1;
    localparam int RW = CW - 1;
    localparam int PW = 2 * DW;
    localparam int SW = 2 * CW;
    localparam int GW = 2 * RW;
    localparam int XW = CW + 5;

    localparam int SQD_STEPS = CW;
    localparam int DIV_STEPS = DW;
    localparam int SQH_STEPS = RW;
    localparam int CCI_LATENCY = 6 + SQD_STEPS + DIV_STEPS + 2 + SQH_STEPS + 1 + DIV_STEPS + 2;

    localparam logic signed [XW-1:0] XMAX = {{(XW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [XW-1:0] XMIN = ~XMAX;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_ONE  = 2'd1,
        KIND_TWO  = 2'd2,
        KIND_INF  = 2'd3
    } kind_t;

    typedef struct packed {
        logic signed [CW-1:0] first_center_x;
        logic signed [CW-1:0] first_center_y;
        logic [RW-1:0]        first_radius;
        logic signed [CW-1:0] second_center_x;
        logic signed [CW-1:0] second_center_y;
        logic [RW-1:0]        second_radius;
    } cci_in_t;

    typedef struct packed {
        kind_t                meet_kind;
        logic signed [CW-1:0] point_a_x;
        logic signed [CW-1:0] point_a_y;
        logic signed [CW-1:0] point_b_x;
        logic signed [CW-1:0] point_b_y;
    } cci_out_t;

    typedef struct packed {
        logic [PW-1:0] rem;
        logic [DW-1:0] root;
    } sq_t;

    typedef struct packed {
        logic [PW-1:0] rem;
        logic [DW-1:0] quo;
    } dv_t;

    // One root bit per call; rem always holds the radicand minus root squared.
    function automatic sq_t sqrt_step(input sq_t s, input int b);
        logic [PW:0] trial;
        sq_t r;
        trial = ((PW+1)'(s.root) << (b + 1)) | ((PW+1)'(1) << (2 * b));
        r = s;
        if ({1'b0, s.rem} >= trial)
        begin
            r.rem  = s.rem - trial[PW-1:0];
            r.root = s.root | (DW'(1) << b);
        end
        return r;
    endfunction

    // One quotient bit per call of a restoring long division.
    function automatic dv_t div_step(input dv_t v, input logic [DW-1:0] den, input int k);
        logic [PW:0] trial;
        dv_t r;
        trial = (PW+1)'(den) << k;
        r = v;
        if ({1'b0, v.rem} >= trial)
        begin
            r.rem = v.rem - trial[PW-1:0];
            r.quo = v.quo | (DW'(1) << k);
        end
        return r;
    endfunction

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [XW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > XMAX)
        begin
            r = {1'b0, {(CW-1){1'b1}}};
        end
        else if (v < XMIN)
        begin
            r = {1'b1, {(CW-1){1'b0}}};
        end
        else
        begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/circle_circle_intersection.sv
// Circle-circle intersection pipeline; depends on cci_pkg.
// An accepted transaction passes through registered stages, including the bit-per-stage
// square roots and dividers, to its done strobe. Throughput is one transaction per cycle;
// busy is always low because the receiver cannot stall. Reset clears all valid bits.
module circle_circle_intersection
    import cci_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  cci_in_t  operands,
    output logic     done,
    output cci_out_t result
);

    typedef struct packed {
        logic                 valid;
        logic signed [CW-1:0] c1x;
        logic signed [CW-1:0] c1y;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic [CW-1:0]        rsum;
        logic [RW-1:0]        gap;
        logic [RW-1:0]        r1;
        logic [RW-1:0]        r2;
        logic                 req;
    } s1_t;

    typedef struct packed {
        logic                 valid;
        logic signed [CW-1:0] c1x;
        logic signed [CW-1:0] c1y;
        logic                 sx;
        logic                 sy;
        logic [DW-1:0]        mdx;
        logic [DW-1:0]        mdy;
        logic [CW-1:0]        rsum;
        logic [RW-1:0]        gap;
        logic [RW-1:0]        r1;
        logic [RW-1:0]        r2;
        logic                 req;
    } s2_t;

    typedef struct packed {
        logic                 valid;
        logic signed [CW-1:0] c1x;
        logic signed [CW-1:0] c1y;
        logic                 sx;
        logic                 sy;
        logic [DW-1:0]        mdx;
        logic [DW-1:0]        mdy;
        logic [PW-1:0]        dx2;
        logic [PW-1:0]        dy2;
        logic [SW-1:0]        s2;
        logic [GW-1:0]        g2;
        logic [GW-1:0]        r1sq;
        logic [GW-1:0]        r2sq;
        logic                 req;
    } s3_t;

    typedef struct packed {
        logic                 valid;
        logic signed [CW-1:0] c1x;
        logic signed [CW-1:0] c1y;
        logic                 sx;
        logic                 sy;
        logic [DW-1:0]        mdx;
        logic [DW-1:0]        mdy;
        logic [PW-1:0]        d2;
        logic [SW-1:0]        s2;
        logic [GW-1:0]        g2;
        logic [GW-1:0]        r1sq;
        logic [GW-1:0]        r2sq;
        logic                 req;
    } s4_t;

    typedef struct packed {
        logic                 valid;
        kind_t                kind;
        logic signed [CW-1:0] c1x;
        logic signed [CW-1:0] c1y;
        logic                 sx;
        logic                 sy;
        logic [DW-1:0]        mdx;
        logic [DW-1:0]        mdy;
        logic [PW-1:0]        d2;
        logic [PW:0]          p;
        logic [GW-1:0]        r1sq;
        logic [GW-1:0]        r2sq;
    } s5_t;

    typedef struct packed {
        logic                 valid;
        kind_t                kind;
        logic signed [CW-1:0] c1x;
        logic signed [CW-1:0] c1y;
        logic                 sx;
        logic                 sy;
        logic [DW-1:0]        mdx;
        logic [DW-1:0]        mdy;
        logic                 neg;
        logic [PW-1:0]        num;
        logic [GW-1:0]        r1sq;
    } ctxa_t;

    typedef struct packed {
        ctxa_t ctx;
        sq_t   sq;
    } sqd_t;

    typedef struct packed {
        logic                 valid;
        kind_t                kind;
        logic signed [CW-1:0] c1x;
        logic signed [CW-1:0] c1y;
        logic                 sx;
        logic                 sy;
        logic [DW-1:0]        mdx;
        logic [DW-1:0]        mdy;
        logic                 neg;
        logic [GW-1:0]        r1sq;
        logic [CW-1:0]        d;
    } ctxb_t;

    typedef struct packed {
        ctxb_t ctx;
        dv_t   dv;
    } diva_t;

    typedef struct packed {
        logic                 valid;
        kind_t                kind;
        logic signed [CW-1:0] c1x;
        logic signed [CW-1:0] c1y;
        logic                 sx;
        logic                 sy;
        logic                 neg;
        logic [CW-1:0]        d;
        logic [DW-1:0]        mdx;
        logic [DW-1:0]        mdy;
        logic [PW-1:0]        aa;
        logic [PW-1:0]        pax;
        logic [PW-1:0]        pay;
        logic [GW-1:0]        r1sq;
    } s7_t;

    typedef struct packed {
        logic                 valid;
        kind_t                kind;
        logic signed [CW-1:0] c1x;
        logic signed [CW-1:0] c1y;
        logic                 sx;
        logic                 sy;
        logic                 neg;
        logic [CW-1:0]        d;
        logic [DW-1:0]        mdx;
        logic [DW-1:0]        mdy;
        logic [PW-1:0]        pax;
        logic [PW-1:0]        pay;
    } ctxc_t;

    typedef struct packed {
        ctxc_t ctx;
        sq_t   sq;
    } sqh_t;

    typedef struct packed {
        logic                 valid;
        kind_t                kind;
        logic signed [CW-1:0] c1x;
        logic signed [CW-1:0] c1y;
        logic                 sx;
        logic                 sy;
        logic                 neg;
        logic [CW-1:0]        d;
    } ctxd_t;

    typedef struct packed {
        ctxd_t ctx;
        dv_t   px;
        dv_t   py;
        dv_t   hx;
        dv_t   hy;
    } div4_t;

    typedef struct packed {
        logic                 valid;
        kind_t                kind;
        logic signed [XW-1:0] px;
        logic signed [XW-1:0] py;
        logic signed [XW-1:0] hx;
        logic signed [XW-1:0] hy;
    } s10_t;

    s1_t      s1_reg, s1_next;
    s2_t      s2_reg, s2_next;
    s3_t      s3_reg, s3_next;
    s4_t      s4_reg, s4_next;
    s5_t      s5_reg, s5_next;
    sqd_t     s6_reg, s6_next;
    sqd_t     sqd_reg [SQD_STEPS];
    diva_t    diva_head;
    diva_t    diva_reg [DIV_STEPS];
    s7_t      s7_reg, s7_next;
    sqh_t     s8_reg, s8_next;
    sqh_t     sqh_reg [SQH_STEPS];
    div4_t    s9_reg, s9_next;
    div4_t    div4_reg [DIV_STEPS];
    s10_t     s10_reg, s10_next;
    cci_out_t result_reg, result_next;
    logic     done_reg, done_next;

    assign busy = 1'b0;

    always_comb
    begin
        s1_next.valid = start && !busy;
        s1_next.c1x   = operands.first_center_x;
        s1_next.c1y   = operands.first_center_y;
        s1_next.dx    = DW'(operands.second_center_x) - DW'(operands.first_center_x);
        s1_next.dy    = DW'(operands.second_center_y) - DW'(operands.first_center_y);
        s1_next.rsum  = CW'(operands.first_radius) + CW'(operands.second_radius);
        s1_next.r1    = operands.first_radius;
        s1_next.r2    = operands.second_radius;
        s1_next.req   = (operands.first_radius == operands.second_radius);
        if (operands.first_radius > operands.second_radius)
        begin
            s1_next.gap = operands.first_radius - operands.second_radius;
        end
        else
        begin
            s1_next.gap = operands.second_radius - operands.first_radius;
        end
    end

    always_comb
    begin
        logic [DW-1:0] ux;
        logic [DW-1:0] uy;
        ux = s1_reg.dx;
        uy = s1_reg.dy;
        s2_next.valid = s1_reg.valid;
        s2_next.c1x   = s1_reg.c1x;
        s2_next.c1y   = s1_reg.c1y;
        s2_next.sx    = ux[DW-1];
        s2_next.sy    = uy[DW-1];
        s2_next.mdx   = ux[DW-1] ? (~ux + DW'(1)) : ux;
        s2_next.mdy   = uy[DW-1] ? (~uy + DW'(1)) : uy;
        s2_next.rsum  = s1_reg.rsum;
        s2_next.gap   = s1_reg.gap;
        s2_next.r1    = s1_reg.r1;
        s2_next.r2    = s1_reg.r2;
        s2_next.req   = s1_reg.req;
    end

    always_comb
    begin
        s3_next.valid = s2_reg.valid;
        s3_next.c1x   = s2_reg.c1x;
        s3_next.c1y   = s2_reg.c1y;
        s3_next.sx    = s2_reg.sx;
        s3_next.sy    = s2_reg.sy;
        s3_next.mdx   = s2_reg.mdx;
        s3_next.mdy   = s2_reg.mdy;
        s3_next.dx2   = PW'(s2_reg.mdx) * PW'(s2_reg.mdx);
        s3_next.dy2   = PW'(s2_reg.mdy) * PW'(s2_reg.mdy);
        s3_next.s2    = SW'(s2_reg.rsum) * SW'(s2_reg.rsum);
        s3_next.g2    = GW'(s2_reg.gap) * GW'(s2_reg.gap);
        s3_next.r1sq  = GW'(s2_reg.r1) * GW'(s2_reg.r1);
        s3_next.r2sq  = GW'(s2_reg.r2) * GW'(s2_reg.r2);
        s3_next.req   = s2_reg.req;
    end

    always_comb
    begin
        s4_next.valid = s3_reg.valid;
        s4_next.c1x   = s3_reg.c1x;
        s4_next.c1y   = s3_reg.c1y;
        s4_next.sx    = s3_reg.sx;
        s4_next.sy    = s3_reg.sy;
        s4_next.mdx   = s3_reg.mdx;
        s4_next.mdy   = s3_reg.mdy;
        s4_next.d2    = s3_reg.dx2 + s3_reg.dy2;
        s4_next.s2    = s3_reg.s2;
        s4_next.g2    = s3_reg.g2;
        s4_next.r1sq  = s3_reg.r1sq;
        s4_next.r2sq  = s3_reg.r2sq;
        s4_next.req   = s3_reg.req;
    end

    always_comb
    begin
        s5_next.valid = s4_reg.valid;
        if (s4_reg.d2 > PW'(s4_reg.s2))
        begin
            s5_next.kind = KIND_NONE;
        end
        else if ((s4_reg.d2 == '0) && s4_reg.req)
        begin
            s5_next.kind = KIND_INF;
        end
        else if (s4_reg.d2 < PW'(s4_reg.g2))
        begin
            s5_next.kind = KIND_NONE;
        end
        else if (s4_reg.d2 == PW'(s4_reg.s2))
        begin
            s5_next.kind = KIND_ONE;
        end
        else
        begin
            s5_next.kind = KIND_TWO;
        end
        s5_next.c1x  = s4_reg.c1x;
        s5_next.c1y  = s4_reg.c1y;
        s5_next.sx   = s4_reg.sx;
        s5_next.sy   = s4_reg.sy;
        s5_next.mdx  = s4_reg.mdx;
        s5_next.mdy  = s4_reg.mdy;
        s5_next.d2   = s4_reg.d2;
        s5_next.p    = (PW+1)'(s4_reg.d2) + (PW+1)'(s4_reg.r1sq);
        s5_next.r1sq = s4_reg.r1sq;
        s5_next.r2sq = s4_reg.r2sq;
    end

    always_comb
    begin
        logic [PW:0] pq;
        logic [PW:0] qp;
        logic        neg;
        pq  = s5_reg.p - (PW+1)'(s5_reg.r2sq);
        qp  = (PW+1)'(s5_reg.r2sq) - s5_reg.p;
        neg = (s5_reg.p < (PW+1)'(s5_reg.r2sq));
        s6_next.ctx.valid = s5_reg.valid;
        s6_next.ctx.kind  = s5_reg.kind;
        s6_next.ctx.c1x   = s5_reg.c1x;
        s6_next.ctx.c1y   = s5_reg.c1y;
        s6_next.ctx.sx    = s5_reg.sx;
        s6_next.ctx.sy    = s5_reg.sy;
        s6_next.ctx.mdx   = s5_reg.mdx;
        s6_next.ctx.mdy   = s5_reg.mdy;
        s6_next.ctx.neg   = neg;
        s6_next.ctx.num   = neg ? qp[PW-1:0] : pq[PW-1:0];
        s6_next.ctx.r1sq  = s5_reg.r1sq;
        s6_next.sq.rem    = s5_reg.d2;
        s6_next.sq.root   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg.valid     <= 1'b0;
            s2_reg.valid     <= 1'b0;
            s3_reg.valid     <= 1'b0;
            s4_reg.valid     <= 1'b0;
            s5_reg.valid     <= 1'b0;
            s6_reg.ctx.valid <= 1'b0;
        end
        else
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            s6_reg <= s6_next;
        end
    end

    for (genvar i = 0; i < SQD_STEPS; i++)
    begin : g_sqd
        sqd_t stage_in;
        sqd_t step_next;
        if (i == 0)
        begin : g_first
            assign stage_in = s6_reg;
        end
        else
        begin : g_rest
            assign stage_in = sqd_reg[i-1];
        end
        always_comb
        begin
            step_next    = stage_in;
            step_next.sq = sqrt_step(stage_in.sq, SQD_STEPS - 1 - i);
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sqd_reg[i].ctx.valid <= 1'b0;
            end
            else
            begin
                sqd_reg[i] <= step_next;
            end
        end
    end

    always_comb
    begin
        diva_head.ctx.valid = sqd_reg[SQD_STEPS-1].ctx.valid;
        diva_head.ctx.kind  = sqd_reg[SQD_STEPS-1].ctx.kind;
        diva_head.ctx.c1x   = sqd_reg[SQD_STEPS-1].ctx.c1x;
        diva_head.ctx.c1y   = sqd_reg[SQD_STEPS-1].ctx.c1y;
        diva_head.ctx.sx    = sqd_reg[SQD_STEPS-1].ctx.sx;
        diva_head.ctx.sy    = sqd_reg[SQD_STEPS-1].ctx.sy;
        diva_head.ctx.mdx   = sqd_reg[SQD_STEPS-1].ctx.mdx;
        diva_head.ctx.mdy   = sqd_reg[SQD_STEPS-1].ctx.mdy;
        diva_head.ctx.neg   = sqd_reg[SQD_STEPS-1].ctx.neg;
        diva_head.ctx.r1sq  = sqd_reg[SQD_STEPS-1].ctx.r1sq;
        diva_head.ctx.d     = sqd_reg[SQD_STEPS-1].sq.root[CW-1:0];
        diva_head.dv.rem    = sqd_reg[SQD_STEPS-1].ctx.num;
        diva_head.dv.quo    = '0;
    end

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_diva
        diva_t stage_in;
        diva_t step_next;
        if (i == 0)
        begin : g_first
            assign stage_in = diva_head;
        end
        else
        begin : g_rest
            assign stage_in = diva_reg[i-1];
        end
        always_comb
        begin
            step_next    = stage_in;
            step_next.dv = div_step(stage_in.dv, {stage_in.ctx.d, 1'b0}, DIV_STEPS - 1 - i);
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                diva_reg[i].ctx.valid <= 1'b0;
            end
            else
            begin
                diva_reg[i] <= step_next;
            end
        end
    end

    always_comb
    begin
        logic [DW-1:0] amag;
        amag          = diva_reg[DIV_STEPS-1].dv.quo;
        s7_next.valid = diva_reg[DIV_STEPS-1].ctx.valid;
        s7_next.kind  = diva_reg[DIV_STEPS-1].ctx.kind;
        s7_next.c1x   = diva_reg[DIV_STEPS-1].ctx.c1x;
        s7_next.c1y   = diva_reg[DIV_STEPS-1].ctx.c1y;
        s7_next.sx    = diva_reg[DIV_STEPS-1].ctx.sx;
        s7_next.sy    = diva_reg[DIV_STEPS-1].ctx.sy;
        s7_next.neg   = diva_reg[DIV_STEPS-1].ctx.neg;
        s7_next.d     = diva_reg[DIV_STEPS-1].ctx.d;
        s7_next.mdx   = diva_reg[DIV_STEPS-1].ctx.mdx;
        s7_next.mdy   = diva_reg[DIV_STEPS-1].ctx.mdy;
        s7_next.aa    = PW'(amag) * PW'(amag);
        s7_next.pax   = PW'(amag) * PW'(diva_reg[DIV_STEPS-1].ctx.mdx);
        s7_next.pay   = PW'(amag) * PW'(diva_reg[DIV_STEPS-1].ctx.mdy);
        s7_next.r1sq  = diva_reg[DIV_STEPS-1].ctx.r1sq;
    end

    always_comb
    begin
        s8_next.ctx.valid = s7_reg.valid;
        s8_next.ctx.kind  = s7_reg.kind;
        s8_next.ctx.c1x   = s7_reg.c1x;
        s8_next.ctx.c1y   = s7_reg.c1y;
        s8_next.ctx.sx    = s7_reg.sx;
        s8_next.ctx.sy    = s7_reg.sy;
        s8_next.ctx.neg   = s7_reg.neg;
        s8_next.ctx.d     = s7_reg.d;
        s8_next.ctx.mdx   = s7_reg.mdx;
        s8_next.ctx.mdy   = s7_reg.mdy;
        s8_next.ctx.pax   = s7_reg.pax;
        s8_next.ctx.pay   = s7_reg.pay;
        s8_next.sq.root   = '0;
        if (PW'(s7_reg.r1sq) > s7_reg.aa)
        begin
            s8_next.sq.rem = PW'(s7_reg.r1sq) - s7_reg.aa;
        end
        else
        begin
            s8_next.sq.rem = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_reg.valid     <= 1'b0;
            s8_reg.ctx.valid <= 1'b0;
        end
        else
        begin
            s7_reg <= s7_next;
            s8_reg <= s8_next;
        end
    end

    for (genvar i = 0; i < SQH_STEPS; i++)
    begin : g_sqh
        sqh_t stage_in;
        sqh_t step_next;
        if (i == 0)
        begin : g_first
            assign stage_in = s8_reg;
        end
        else
        begin : g_rest
            assign stage_in = sqh_reg[i-1];
        end
        always_comb
        begin
            step_next    = stage_in;
            step_next.sq = sqrt_step(stage_in.sq, SQH_STEPS - 1 - i);
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sqh_reg[i].ctx.valid <= 1'b0;
            end
            else
            begin
                sqh_reg[i] <= step_next;
            end
        end
    end

    always_comb
    begin
        logic [RW-1:0] h;
        h                 = sqh_reg[SQH_STEPS-1].sq.root[RW-1:0];
        s9_next.ctx.valid = sqh_reg[SQH_STEPS-1].ctx.valid;
        s9_next.ctx.kind  = sqh_reg[SQH_STEPS-1].ctx.kind;
        s9_next.ctx.c1x   = sqh_reg[SQH_STEPS-1].ctx.c1x;
        s9_next.ctx.c1y   = sqh_reg[SQH_STEPS-1].ctx.c1y;
        s9_next.ctx.sx    = sqh_reg[SQH_STEPS-1].ctx.sx;
        s9_next.ctx.sy    = sqh_reg[SQH_STEPS-1].ctx.sy;
        s9_next.ctx.neg   = sqh_reg[SQH_STEPS-1].ctx.neg;
        s9_next.ctx.d     = sqh_reg[SQH_STEPS-1].ctx.d;
        s9_next.px.rem    = sqh_reg[SQH_STEPS-1].ctx.pax;
        s9_next.px.quo    = '0;
        s9_next.py.rem    = sqh_reg[SQH_STEPS-1].ctx.pay;
        s9_next.py.quo    = '0;
        s9_next.hx.rem    = PW'(h) * PW'(sqh_reg[SQH_STEPS-1].ctx.mdy);
        s9_next.hx.quo    = '0;
        s9_next.hy.rem    = PW'(h) * PW'(sqh_reg[SQH_STEPS-1].ctx.mdx);
        s9_next.hy.quo    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s9_reg.ctx.valid <= 1'b0;
        end
        else
        begin
            s9_reg <= s9_next;
        end
    end

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div4
        div4_t stage_in;
        div4_t step_next;
        if (i == 0)
        begin : g_first
            assign stage_in = s9_reg;
        end
        else
        begin : g_rest
            assign stage_in = div4_reg[i-1];
        end
        always_comb
        begin
            step_next    = stage_in;
            step_next.px = div_step(stage_in.px, DW'(stage_in.ctx.d), DIV_STEPS - 1 - i);
            step_next.py = div_step(stage_in.py, DW'(stage_in.ctx.d), DIV_STEPS - 1 - i);
            step_next.hx = div_step(stage_in.hx, DW'(stage_in.ctx.d), DIV_STEPS - 1 - i);
            step_next.hy = div_step(stage_in.hy, DW'(stage_in.ctx.d), DIV_STEPS - 1 - i);
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div4_reg[i].ctx.valid <= 1'b0;
            end
            else
            begin
                div4_reg[i] <= step_next;
            end
        end
    end

    always_comb
    begin
        logic [XW-1:0] tpx;
        logic [XW-1:0] tpy;
        logic [XW-1:0] thx;
        logic [XW-1:0] thy;
        logic          spx;
        logic          spy;
        tpx = XW'(div4_reg[DIV_STEPS-1].px.quo);
        tpy = XW'(div4_reg[DIV_STEPS-1].py.quo);
        thx = XW'(div4_reg[DIV_STEPS-1].hx.quo);
        thy = XW'(div4_reg[DIV_STEPS-1].hy.quo);
        spx = div4_reg[DIV_STEPS-1].ctx.neg ^ div4_reg[DIV_STEPS-1].ctx.sx;
        spy = div4_reg[DIV_STEPS-1].ctx.neg ^ div4_reg[DIV_STEPS-1].ctx.sy;
        s10_next.valid = div4_reg[DIV_STEPS-1].ctx.valid;
        s10_next.kind  = div4_reg[DIV_STEPS-1].ctx.kind;
        s10_next.px    = $signed(XW'(div4_reg[DIV_STEPS-1].ctx.c1x))
                       + $signed(spx ? (~tpx + XW'(1)) : tpx);
        s10_next.py    = $signed(XW'(div4_reg[DIV_STEPS-1].ctx.c1y))
                       + $signed(spy ? (~tpy + XW'(1)) : tpy);
        s10_next.hx    = $signed(div4_reg[DIV_STEPS-1].ctx.sy ? (~thx + XW'(1)) : thx);
        s10_next.hy    = $signed(div4_reg[DIV_STEPS-1].ctx.sx ? (~thy + XW'(1)) : thy);
    end

    always_comb
    begin
        result_next.meet_kind = s10_reg.kind;
        result_next.point_a_x = '0;
        result_next.point_a_y = '0;
        result_next.point_b_x = '0;
        result_next.point_b_y = '0;
        case (s10_reg.kind)
            KIND_ONE:
            begin
                result_next.point_a_x = sat_coord(s10_reg.px + s10_reg.hx);
                result_next.point_a_y = sat_coord(s10_reg.py - s10_reg.hy);
            end
            KIND_TWO:
            begin
                result_next.point_a_x = sat_coord(s10_reg.px + s10_reg.hx);
                result_next.point_a_y = sat_coord(s10_reg.py - s10_reg.hy);
                result_next.point_b_x = sat_coord(s10_reg.px - s10_reg.hx);
                result_next.point_b_y = sat_coord(s10_reg.py + s10_reg.hy);
            end
            default:
            begin
                result_next.point_a_x = '0;
            end
        endcase
        done_next = s10_reg.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s10_reg.valid <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            s10_reg  <= s10_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: rtl/cci_checker.sv
// Port-level checker for the circle intersection block, bound to the top level.
// Depends on cci_pkg for the latency and the kind codes.
module cci_checker
    import cci_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     done,
    input cci_out_t result
);

    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, CCI_LATENCY))
        else $error("done strobe without a matching transaction");

    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##CCI_LATENCY done)
        else $error("transaction produced no result");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.meet_kind == KIND_NONE || result.meet_kind == KIND_INF)) |->
        (result.point_a_x == '0 && result.point_a_y == '0 &&
         result.point_b_x == '0 && result.point_b_y == '0))
        else $error("points not zero for an empty or coincident result");

    a_single_b_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.meet_kind == KIND_ONE) |->
        (result.point_b_x == '0 && result.point_b_y == '0))
        else $error("second point not zero for a tangent result");

endmodule

bind circle_circle_intersection cci_checker u_cci_checker (.*);
